// ----- design/nehf_pkg.sv -----
package nehf_pkg;

  // register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_ACTION = 1'd1;

  // failsafe action codes
  localparam logic [1:0] ACTION_NONE = 2'd0;
  localparam logic [1:0] ACTION_REPORT = 2'd1;
  localparam logic [1:0] ACTION_HOLD = 2'd2;

  // reset values of the registers
  localparam logic [15:0] THRESHOLD_RESET = 16'd3277;
  localparam logic [1:0] ACTION_RESET = ACTION_HOLD;

  // defaults of the top level parameters
  localparam int unsigned FAIL_LIMIT_DEFAULT = 10;
  localparam logic [31:0] WARN_INTERVAL_MS_DEFAULT = 32'd30000;

  // depth of the queue between classifier and state update
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // nav_flags bit positions
  localparam int unsigned NAV_INERTIAL = 0;
  localparam int unsigned NAV_ABS_POS = 1;
  localparam int unsigned NAV_REL_POS = 2;
  localparam int unsigned NAV_CONST_POS = 3;

  typedef struct packed {
    logic        origin_set;
    logic        armed;
    logic [15:0] mag_var_x;
    logic [15:0] mag_var_y;
    logic [15:0] mag_var_z;
    logic [15:0] vel_var;
    logic [15:0] pos_var;
    logic        optflow_ok;
    logic [3:0]  nav_flags;
    logic        mode_needs_position;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic ekf_bad;
    logic failsafe_on;
    logic ev_bad_variance;
    logic ev_variance_cleared;
    logic ev_failsafe_enter;
    logic ev_failsafe_exit;
    logic ev_hold_request;
    logic ev_variance_warning;
    logic ev_failsafe_alert;
  } result_t;

  // classified tick handed from the front to the back
  typedef struct packed {
    logic        origin_set;
    logic        reset_state;
    logic        bad_tick;
    logic        needs_pos;
    logic [31:0] now_ms;
  } cmd_t;

endpackage

// ----- design/nehf_front.sv -----
module nehf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  nehf_pkg::item_t    item_i,
  input  logic [15:0]        threshold_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output nehf_pkg::cmd_t     cmd_o
);

  logic        s1_valid_q;
  logic [31:0] sq_x_q, sq_y_q, sq_z_q, thr_sq_q;
  logic        vel_ge_q, vel_ge2_q, pos_ge_q, flow_ok_q, pos_ok_q;
  logic        origin_q, reset_state_q, needs_pos_q;
  logic [31:0] now_q;

  logic [16:0] thr_x2;
  logic [33:0] mag_sum;
  logic        mag_hit;
  logic [2:0]  hit_cnt;

  assign thr_x2 = {threshold_i, 1'b0};

  // stage one valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end

  // stage one: squares and single compares
  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      sq_x_q        <= 32'(item_i.mag_var_x) * 32'(item_i.mag_var_x);
      sq_y_q        <= 32'(item_i.mag_var_y) * 32'(item_i.mag_var_y);
      sq_z_q        <= 32'(item_i.mag_var_z) * 32'(item_i.mag_var_z);
      thr_sq_q      <= 32'(threshold_i) * 32'(threshold_i);
      vel_ge_q      <= item_i.vel_var >= threshold_i;
      vel_ge2_q     <= 17'(item_i.vel_var) >= thr_x2;
      pos_ge_q      <= item_i.pos_var >= threshold_i;
      flow_ok_q     <= item_i.optflow_ok;
      pos_ok_q      <= item_i.nav_flags[nehf_pkg::NAV_INERTIAL]
                       && (item_i.nav_flags[nehf_pkg::NAV_ABS_POS]
                           || item_i.nav_flags[nehf_pkg::NAV_REL_POS])
                       && !item_i.nav_flags[nehf_pkg::NAV_CONST_POS];
      origin_q      <= item_i.origin_set;
      reset_state_q <= !item_i.armed || (threshold_i == 16'd0);
      needs_pos_q   <= item_i.mode_needs_position;
      now_q         <= item_i.now_ms;
    end
  end

  // stage two: compass magnitude and variance count
  always_comb begin
    mag_sum = 34'(sq_x_q) + 34'(sq_y_q) + 34'(sq_z_q);
    mag_hit = mag_sum >= 34'(thr_sq_q);
    hit_cnt = 3'(mag_hit) + 3'(vel_ge_q) + 3'(pos_ge_q);
    if (!flow_ok_q && vel_ge2_q) begin
      hit_cnt = hit_cnt + 3'd2;
    end else if (vel_ge_q) begin
      hit_cnt = hit_cnt + 3'd1;
    end
  end

  assign cmd_valid_o        = s1_valid_q;
  assign cmd_o.origin_set   = origin_q;
  assign cmd_o.reset_state  = reset_state_q;
  assign cmd_o.bad_tick     = (hit_cnt >= 3'd2) || !pos_ok_q;
  assign cmd_o.needs_pos    = needs_pos_q;
  assign cmd_o.now_ms       = now_q;
  assign busy_o             = s1_valid_q;

endmodule

// ----- design/nehf_queue.sv -----
module nehf_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  nehf_pkg::cmd_t                      wr_data_i,
  input  logic                                rd_en_i,
  output logic                                rd_valid_o,
  output nehf_pkg::cmd_t                      rd_data_o,
  output logic [nehf_pkg::QUEUE_CNT_W-1:0]    count_o
);

  nehf_pkg::cmd_t                       mem_q [nehf_pkg::QUEUE_DEPTH];
  logic [nehf_pkg::QUEUE_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [nehf_pkg::QUEUE_CNT_W-1:0]     count_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + 1'b1;
      end else if (!wr_en_i && rd_en_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign count_o    = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_en_i && !rd_en_i
      && count_q == nehf_pkg::QUEUE_CNT_W'(nehf_pkg::QUEUE_DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> count_q != '0)
    else $error("queue read while empty");

endmodule

// ----- design/nehf_back.sv -----
module nehf_back #(
  parameter int unsigned  FAIL_LIMIT = nehf_pkg::FAIL_LIMIT_DEFAULT,
  parameter logic [31:0]  WARN_INTERVAL_MS = nehf_pkg::WARN_INTERVAL_MS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  nehf_pkg::cmd_t    cmd_i,
  output logic              cmd_take_o,
  input  logic [1:0]        action_i,
  output logic              out_valid_o,
  output nehf_pkg::result_t result_o,
  input  logic              out_take_i
);

  localparam int unsigned CntW = $clog2(FAIL_LIMIT + 1);
  localparam logic [CntW-1:0] Limit = CntW'(FAIL_LIMIT);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              bad_q, bad_d;
  logic              fs_q, fs_d;
  logic [31:0]       last_warn_q, last_warn_d;
  logic              out_valid_q;
  nehf_pkg::result_t result_q, res_d;
  logic [CntW:0]     cnt_inc;
  logic [CntW-1:0]   cnt_dec;
  logic [31:0]       since_warn;

  // take a transaction when the output register is free or drains now
  assign cmd_take_o = cmd_valid_i && (!out_valid_q || out_take_i);

  // state update for one tick
  always_comb begin
    cnt_d       = cnt_q;
    bad_d       = bad_q;
    fs_d        = fs_q;
    last_warn_d = last_warn_q;
    res_d       = '0;
    cnt_inc     = {1'b0, cnt_q} + 1'b1;
    cnt_dec     = cnt_q - 1'b1;
    since_warn  = cmd_i.now_ms - last_warn_q;
    if (cmd_i.origin_set) begin
      if (cmd_i.reset_state) begin
        cnt_d = '0;
        bad_d = 1'b0;
        if (fs_q) begin
          fs_d = 1'b0;
          res_d.ev_failsafe_exit = 1'b1;
        end
      end else if (cmd_i.bad_tick) begin
        if (!bad_q) begin
          cnt_d = cnt_inc[CntW-1:0];
          if (cnt_inc >= {1'b0, Limit}) begin
            cnt_d = Limit;
            bad_d = 1'b1;
            res_d.ev_bad_variance = 1'b1;
            if (since_warn > WARN_INTERVAL_MS) begin
              res_d.ev_variance_warning = 1'b1;
              last_warn_d = cmd_i.now_ms;
            end
            if (!fs_q) begin
              fs_d = 1'b1;
              res_d.ev_failsafe_enter = 1'b1;
              if (cmd_i.needs_pos && action_i != nehf_pkg::ACTION_NONE) begin
                res_d.ev_hold_request = action_i != nehf_pkg::ACTION_REPORT;
                res_d.ev_failsafe_alert = 1'b1;
              end
            end
          end
        end
      end else if (cnt_q != '0) begin
        cnt_d = cnt_dec;
        if (bad_q && cnt_dec == '0) begin
          bad_d = 1'b0;
          res_d.ev_variance_cleared = 1'b1;
          if (fs_q) begin
            fs_d = 1'b0;
            res_d.ev_failsafe_exit = 1'b1;
          end
        end
      end
    end
    res_d.ekf_bad     = bad_d;
    res_d.failsafe_on = fs_d;
  end

  // health state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      bad_q       <= 1'b0;
      fs_q        <= 1'b0;
      last_warn_q <= '0;
    end else if (cmd_take_o) begin
      cnt_q       <= cnt_d;
      bad_q       <= bad_d;
      fs_q        <= fs_d;
      last_warn_q <= last_warn_d;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_take_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_take_o) begin
      result_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  a_failsafe_needs_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fs_q |-> bad_q)
    else $error("failsafe active without bad-variance flag");

  a_bad_needs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bad_q |-> (cnt_q != '0 && cnt_q <= Limit))
    else $error("bad-variance flag with counter out of range");

endmodule

// ----- design/nav_estimator_health_failsafe.sv -----
// Estimator health failsafe. One tick is taken per clock cycle while full is
// low; its result reaches the result ports through these registers in turn:
// the classifier registers its squares and compares at the accepting edge,
// the four-entry queue then takes the classified tick, and the output
// register behind the state update loads it once that register is free or
// being popped. The sustained rate of one tick per cycle is set by the counter
// and flag update in the back end; full rises only when the output side
// stalls long enough to fill the queue. Configuration writes take effect at
// once and should be made only while no tick is in flight.
module nav_estimator_health_failsafe #(
  parameter int unsigned  FAIL_LIMIT = nehf_pkg::FAIL_LIMIT_DEFAULT,
  parameter logic [31:0]  WARN_INTERVAL_MS = nehf_pkg::WARN_INTERVAL_MS_DEFAULT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  nehf_pkg::item_t                     item_i,
  output logic                                empty,
  input  logic                                pop,
  output nehf_pkg::result_t                   result_o,
  input  logic                                cfg_we_i,
  input  logic [nehf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [nehf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic [15:0]                      threshold_q;
  logic [1:0]                       action_q;
  logic                             in_take;
  logic                             front_busy;
  logic                             cmd_valid;
  nehf_pkg::cmd_t                   cmd, q_cmd;
  logic                             q_valid, q_take;
  logic [nehf_pkg::QUEUE_CNT_W-1:0] q_count;
  logic                             out_valid;
  logic                             out_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= nehf_pkg::THRESHOLD_RESET;
      action_q    <= nehf_pkg::ACTION_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nehf_pkg::REG_VARIANCE_THRESHOLD: threshold_q <= cfg_data_i[15:0];
        nehf_pkg::REG_FAILSAFE_ACTION:    action_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // room for every transaction already in the classifier
  assign full    = ({1'b0, q_count} + 4'(front_busy))
                   >= 4'(nehf_pkg::QUEUE_DEPTH);
  assign in_take = push && !full;

  nehf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_take),
    .item_i      (item_i),
    .threshold_i (threshold_q),
    .busy_o      (front_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  nehf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cmd_valid),
    .wr_data_i  (cmd),
    .rd_en_i    (q_take),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_cmd),
    .count_o    (q_count)
  );

  nehf_back #(
    .FAIL_LIMIT       (FAIL_LIMIT),
    .WARN_INTERVAL_MS (WARN_INTERVAL_MS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_take_o  (q_take),
    .action_i    (action_q),
    .out_valid_o (out_valid),
    .result_o    (result_o),
    .out_take_i  (out_take)
  );

  assign empty    = !out_valid;
  assign out_take = pop && out_valid;

endmodule

// ----- tb/sv/nav_estimator_health_failsafe_tb.sv -----
`timescale 1ns / 100ps

module nav_estimator_health_failsafe_tb;
  import nehf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_TICKS = 500;
  localparam int unsigned MAX_REPORTS = 10;
  // action code 3 is not named by the package but behaves like hold
  localparam logic [1:0] ACTION_SPARE = 2'd3;

  typedef enum int {NEED_CLEAR, NEED_SET, NEED_ANY} position_need_e;
  typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW, DRAIN_BLOCKED} drain_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push;
  logic full;
  item_t item_i;
  logic empty;
  logic pop;
  result_t result_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // health state mirrored from the register writes and accepted ticks
  logic [15:0] thr_q = THRESHOLD_RESET;
  logic [1:0] act_q = ACTION_RESET;
  int unsigned fail_cnt = 0;
  logic bad_q = 1'b0;
  logic fs_q = 1'b0;
  logic [31:0] last_warn_ms = '0;

  result_t pending_status_q[$];
  logic [31:0] sim_ms = '0;
  int burst_left = 8;
  int unsigned quiet_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_ticks = 0;
  int unsigned random_ticks = 0;
  int unsigned n_checked = 0;
  int unsigned n_bad_sets = 0;
  int unsigned n_clears = 0;
  int unsigned n_entries = 0;
  int unsigned n_holds = 0;
  int unsigned n_warnings = 0;

  nav_estimator_health_failsafe u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .item_i(item_i),
    .empty(empty),
    .pop(pop),
    .result_o(result_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit nav_usable(input logic [3:0] nf);
    return nf[NAV_INERTIAL] && (nf[NAV_ABS_POS] || nf[NAV_REL_POS]) && !nf[NAV_CONST_POS];
  endfunction

  // next status for one tick, advancing the mirrored state
  function automatic result_t predict_status(input item_t it);
    result_t r;
    logic [33:0] mag_sq;
    logic [33:0] thr_sq;
    int unsigned hits;
    r = '0;
    if (it.origin_set) begin
      if (!it.armed || thr_q == 16'd0) begin
        fail_cnt = 0;
        bad_q = 1'b0;
        if (fs_q) begin
          fs_q = 1'b0;
          r.ev_failsafe_exit = 1'b1;
        end
      end else begin
        mag_sq = 34'(it.mag_var_x) * 34'(it.mag_var_x) + 34'(it.mag_var_y) * 34'(it.mag_var_y)
                 + 34'(it.mag_var_z) * 34'(it.mag_var_z);
        thr_sq = 34'(thr_q) * 34'(thr_q);
        hits = 0;
        if (mag_sq >= thr_sq) hits++;
        if (it.vel_var >= thr_q) hits++;
        if (it.pos_var >= thr_q) hits++;
        // velocity is counted a second time, double when flow is lost
        if (!it.optflow_ok && 17'(it.vel_var) >= {thr_q, 1'b0}) hits += 2;
        else if (it.vel_var >= thr_q) hits++;
        if (hits >= 2 || !nav_usable(it.nav_flags)) begin
          if (!bad_q) begin
            fail_cnt++;
            if (fail_cnt >= FAIL_LIMIT_DEFAULT) begin
              fail_cnt = FAIL_LIMIT_DEFAULT;
              bad_q = 1'b1;
              r.ev_bad_variance = 1'b1;
              if (32'(it.now_ms - last_warn_ms) > WARN_INTERVAL_MS_DEFAULT) begin
                r.ev_variance_warning = 1'b1;
                last_warn_ms = it.now_ms;
              end
              if (!fs_q) begin
                fs_q = 1'b1;
                r.ev_failsafe_enter = 1'b1;
                if (it.mode_needs_position && act_q != ACTION_NONE) begin
                  if (act_q != ACTION_REPORT) r.ev_hold_request = 1'b1;
                  r.ev_failsafe_alert = 1'b1;
                end
              end
            end
          end
        end else if (fail_cnt > 0) begin
          fail_cnt--;
          if (bad_q && fail_cnt == 0) begin
            bad_q = 1'b0;
            r.ev_variance_cleared = 1'b1;
            if (fs_q) begin
              fs_q = 1'b0;
              r.ev_failsafe_exit = 1'b1;
            end
          end
        end
      end
    end
    r.ekf_bad = bad_q;
    r.failsafe_on = fs_q;
    return r;
  endfunction

  function automatic string diff_fields(input result_t want, input result_t got);
    string d = "";
    if (want.ekf_bad !== got.ekf_bad) d = {d, " ekf_bad"};
    if (want.failsafe_on !== got.failsafe_on) d = {d, " failsafe_on"};
    if (want.ev_bad_variance !== got.ev_bad_variance) d = {d, " ev_bad_variance"};
    if (want.ev_variance_cleared !== got.ev_variance_cleared) d = {d, " ev_variance_cleared"};
    if (want.ev_failsafe_enter !== got.ev_failsafe_enter) d = {d, " ev_failsafe_enter"};
    if (want.ev_failsafe_exit !== got.ev_failsafe_exit) d = {d, " ev_failsafe_exit"};
    if (want.ev_hold_request !== got.ev_hold_request) d = {d, " ev_hold_request"};
    if (want.ev_variance_warning !== got.ev_variance_warning) d = {d, " ev_variance_warning"};
    if (want.ev_failsafe_alert !== got.ev_failsafe_alert) d = {d, " ev_failsafe_alert"};
    return d;
  endfunction

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // armed tick with a usable position and zero variances
  function automatic item_t clean_tick(input logic [31:0] now);
    item_t it;
    it = '0;
    it.origin_set = 1'b1;
    it.armed = 1'b1;
    it.optflow_ok = 1'b1;
    it.nav_flags[NAV_INERTIAL] = 1'b1;
    it.nav_flags[NAV_ABS_POS] = 1'b1;
    it.now_ms = now;
    return it;
  endfunction

  function automatic item_t base_tick();
    item_t it;
    sim_ms += 32'($urandom_range(0, 9000));
    it = clean_tick(sim_ms);
    it.optflow_ok = 1'($urandom_range(0, 1));
    it.nav_flags[NAV_ABS_POS +: 2] = 2'($urandom_range(1, 3));
    it.mode_needs_position = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // at most one count and a usable position
  function automatic item_t good_tick();
    item_t it;
    int t;
    t = (thr_q == 16'd0) ? 1 : int'(thr_q);
    it = base_tick();
    it.vel_var = 16'($urandom_range(0, t - 1));
    it.pos_var = 16'($urandom_range(0, t - 1));
    it.mag_var_x = 16'($urandom_range(0, t / 2));
    it.mag_var_y = 16'($urandom_range(0, t / 2));
    it.mag_var_z = 16'($urandom_range(0, t / 2));
    case ($urandom_range(0, 2))
      0: ;
      1: it.pos_var = 16'($urandom());
      default: begin
        it.mag_var_x = 16'($urandom());
        it.mag_var_y = 16'($urandom());
        it.mag_var_z = 16'($urandom());
      end
    endcase
    return it;
  endfunction

  // mostly bad; the compass case sits around the boundary
  function automatic item_t bad_tick();
    item_t it;
    logic [3:0] nf;
    int t;
    t = (thr_q == 16'd0) ? 1 : int'(thr_q);
    it = base_tick();
    case ($urandom_range(0, 3))
      0: begin
        it.mag_var_x = 16'($urandom());
        it.mag_var_y = 16'($urandom());
        it.mag_var_z = 16'($urandom());
        it.vel_var = 16'($urandom());
        it.pos_var = 16'($urandom());
        do nf = 4'($urandom_range(0, 15)); while (nav_usable(nf));
        it.nav_flags = nf;
      end
      1: it.vel_var = 16'($urandom_range(t, 65535));
      2: begin
        it.mag_var_x = 16'($urandom_range(t / 2, t));
        it.mag_var_y = 16'($urandom_range(t / 2, t));
        it.mag_var_z = 16'($urandom_range(t / 2, t));
        it.pos_var = 16'($urandom_range(t, 65535));
        it.vel_var = 16'($urandom_range(0, t - 1));
      end
      default: begin
        if (2 * t <= 65535) begin
          it.optflow_ok = 1'b0;
          it.vel_var = 16'($urandom_range(2 * t, 65535));
        end else begin
          it.vel_var = 16'hFFFF;
        end
      end
    endcase
    return it;
  endfunction

  function automatic item_t noise_tick();
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    return raw[$bits(item_t)-1:0];
  endfunction

  // one transaction on the input side, then the sender's burst pacing
  task automatic send_tick(input item_t it);
    result_t r;
    item_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
    r = predict_status(it);
    pending_status_q.push_back(r);
    n_ticks++;
    n_bad_sets += r.ev_bad_variance;
    n_clears += r.ev_variance_cleared;
    n_entries += r.ev_failsafe_enter;
    n_holds += r.ev_hold_request;
    n_warnings += r.ev_variance_warning;
    burst_left--;
    if (burst_left <= 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // hold off the sender until every status has come back
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_status_q.size() != 0);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [1:0] act);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_VARIANCE_THRESHOLD;
    cfg_data_i <= thr;
    @(posedge clk_i);
    thr_q = thr;
    cfg_idx_i <= REG_FAILSAFE_ACTION;
    cfg_data_i <= {14'd0, act};
    @(posedge clk_i);
    act_q = act;
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_burst(input int n, input int bad_pct, input position_need_e need,
                           input int noise_pct);
    item_t it;
    repeat (n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        it = noise_tick();
      end else begin
        it = ($urandom_range(0, 99) < bad_pct) ? bad_tick() : good_tick();
        if (need != NEED_ANY) it.mode_needs_position = (need == NEED_SET);
      end
      if (it.origin_set) random_ticks++;
      send_tick(it);
    end
  endtask

  // field extremes, counting rules and the path into and out of failsafe
  task automatic test_directed_cases();
    item_t it;
    // origin unknown with everything else at maximum: state held
    it = '1;
    it.origin_set = 1'b0;
    send_tick(it);
    // disarmed with the worst variances
    it = '1;
    it.armed = 1'b0;
    send_tick(it);
    send_tick(clean_tick(32'd100));
    // relative position only, full compass alone, velocity just under the limit
    it = clean_tick(32'd200);
    it.nav_flags = 4'b0101;
    it.mag_var_x = '1;
    it.mag_var_y = '1;
    it.mag_var_z = '1;
    it.optflow_ok = 1'b0;
    it.vel_var = THRESHOLD_RESET - 16'd1;
    send_tick(it);
    // compass one under the limit, position at it: a single count
    it = clean_tick(32'd300);
    it.mag_var_x = THRESHOLD_RESET - 16'd1;
    it.pos_var = THRESHOLD_RESET;
    send_tick(it);
    // compass exactly at the limit
    it.mag_var_x = THRESHOLD_RESET;
    send_tick(it);
    // velocity at the limit with healthy flow counts twice
    it = clean_tick(32'd400);
    it.vel_var = THRESHOLD_RESET;
    send_tick(it);
    // flow lost, velocity at and just under twice the limit
    it.optflow_ok = 1'b0;
    it.vel_var = {THRESHOLD_RESET[14:0], 1'b0};
    send_tick(it);
    it.vel_var = {THRESHOLD_RESET[14:0], 1'b0} - 16'd1;
    send_tick(it);
    // unusable position estimates
    it = clean_tick(32'd500);
    it.nav_flags = 4'b1011;
    send_tick(it);
    it.nav_flags = 4'b0001;
    send_tick(it);
    it.nav_flags = 4'b0110;
    send_tick(it);
    // a good tick walks the counter back by one
    send_tick(clean_tick(32'd600));
    // four more bad ticks hit the limit with position needed and hold selected
    it = clean_tick(32'hFFFF_FFFF);
    it.nav_flags = 4'b0000;
    it.mode_needs_position = 1'b1;
    repeat (4) send_tick(it);
    // bad tick while the flag is already up
    send_tick(it);
    // disarm ends the failsafe
    it.armed = 1'b0;
    send_tick(it);
  endtask

  task automatic test_threshold_extremes();
    // zero turns the check off
    configure(16'd0, ACTION_HOLD);
    run_burst(8, 100, NEED_ANY, 0);
    configure(16'd1, ACTION_HOLD);
    run_burst(12, 100, NEED_ANY, 0);
    run_burst(12, 0, NEED_ANY, 0);
    configure(16'hFFFF, ACTION_REPORT);
    run_burst(12, 100, NEED_ANY, 0);
    run_burst(12, 0, NEED_ANY, 0);
  endtask

  // full ramp up and recovery under every action, with and without position need
  task automatic test_failsafe_actions();
    logic [1:0] codes [4] = '{ACTION_NONE, ACTION_REPORT, ACTION_HOLD, ACTION_SPARE};
    foreach (codes[i]) begin
      configure(THRESHOLD_RESET, codes[i]);
      run_burst(11, 100, NEED_SET, 0);
      run_burst(10, 0, NEED_SET, 0);
      run_burst(11, 100, NEED_CLEAR, 0);
      run_burst(10, 0, NEED_CLEAR, 0);
    end
  endtask

  task automatic test_random_phases();
    logic [15:0] thr;
    logic [1:0] act;
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 9))
        0: thr = 16'd0;
        1: thr = 16'd1;
        2: thr = 16'hFFFF;
        3, 4: thr = 16'($urandom());
        default: thr = 16'($urandom_range(500, 12000));
      endcase
      act = ($urandom_range(0, 9) == 0) ? ACTION_SPARE : 2'($urandom_range(0, 2));
      configure(thr, act);
      if ($urandom_range(0, 7) == 0) sim_ms = $urandom();
      // mostly bad to climb the counter, then mostly good to recover
      run_burst($urandom_range(12, 25), $urandom_range(70, 100), NEED_ANY, 6);
      run_burst($urandom_range(12, 25), $urandom_range(0, 25), NEED_ANY, 6);
    end
  endtask

  // status checker with its own pop pattern
  always @(posedge clk_i) begin : check_status
    string diff;
    result_t want;
    drain_mode_e mode;
    int unsigned phase;
    if (rst_ni) begin
      if (pop && !empty) begin
        n_checked++;
        if (pending_status_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected status %b", result_o));
        end else begin
          want = pending_status_q.pop_front();
          diff = diff_fields(want, result_o);
          if (diff != "")
            flag_mismatch($sformatf("status %0d differs in%s: expected %b, got %b",
                                    n_checked, diff, want, result_o));
        end
      end
      phase++;
      if (phase % 48 == 0) mode = drain_mode_e'($urandom_range(0, 3));
      case (mode)
        DRAIN_FREE: pop <= 1'b1;
        DRAIN_HALF: pop <= 1'($urandom_range(0, 1));
        DRAIN_SLOW: pop <= ($urandom_range(0, 4) == 0);
        default: pop <= (phase % 48) >= 40;
      endcase
    end
  end

  // cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    do @(posedge clk_i); while (quiet_cycles < QUIET_LIMIT);
    $display("timeout after %0d quiet cycles", quiet_cycles);
    $display("nav_estimator_health_failsafe_tb: done, errors");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    item_i = '0;
    pop = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_threshold_extremes();
    test_failsafe_actions();
    test_random_phases();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d ticks (%0d in random sequences), %0d statuses checked, %0d mismatches",
             n_ticks, random_ticks, n_checked, n_errors);
    $display("events: %0d bad-variance sets, %0d clears, %0d failsafe entries, %0d holds, %0d warnings",
             n_bad_sets, n_clears, n_entries, n_holds, n_warnings);
    if (n_errors == 0) begin
      $display("nav_estimator_health_failsafe_tb: done, clean");
    end else begin
      $display("nav_estimator_health_failsafe_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/nehf_pkg.sv
design/nehf_front.sv
design/nehf_queue.sv
design/nehf_back.sv
design/nav_estimator_health_failsafe.sv
tb/sv/nav_estimator_health_failsafe_tb.sv
